>>> hw/rtl/rmsf_pkg.sv
package rmsf_pkg;

  localparam int DATA_W      = 16;
  localparam int WINDOW_SIZE = 5;
  localparam int WIN_IDX_W   = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
  localparam int MED_RANK    = WINDOW_SIZE / 2;

  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 4;

  localparam logic [DATA_W-1:0] SLEW_STEP   = 16'd5;
  localparam logic [DATA_W-1:0] ALARM_VALUE = 16'd1;
  localparam logic [DATA_W-1:0] LAST_RESET  = 16'd100;

  localparam logic [DATA_W-1:0] MAX_VALID_RESET = 16'd400;
  localparam logic [DATA_W-1:0] NEAR_ZONE_RESET = 16'd20;
  localparam logic [DATA_W-1:0] MAX_JUMP_RESET  = 16'd50;

  typedef enum logic [1:0] {
    REG_MAX_VALID,
    REG_NEAR_ZONE,
    REG_MAX_JUMP
  } cfg_reg_t;

  typedef struct packed {
    logic [DATA_W-1:0] valid_limit;
    logic [DATA_W-1:0] near_limit;
    logic [DATA_W-1:0] jump_limit;
  } cfg_t;

  typedef logic [WINDOW_SIZE-1:0][DATA_W-1:0] win_t;

  typedef struct packed {
    logic [CNT_W-1:0] lt_cnt;
    logic [CNT_W-1:0] le_cnt;
  } rank_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANK,
    ST_DIFF,
    ST_SLEW,
    ST_HOLD
  } state_t;

endpackage

>>> hw/rtl/rmsf_in_if.sv
interface rmsf_in_if;
  logic                            valid;
  logic                            ready;
  logic [rmsf_pkg::DATA_W-1:0]     raw_distance;

  modport source (output valid, output raw_distance, input ready);
  modport sink   (input valid, input raw_distance, output ready);
endinterface

>>> hw/rtl/rmsf_out_if.sv
interface rmsf_out_if;
  logic                            valid;
  logic                            ready;
  logic [rmsf_pkg::DATA_W-1:0]     filtered_distance;

  modport source (output valid, output filtered_distance, input ready);
  modport sink   (input valid, input filtered_distance, output ready);
endinterface

>>> hw/rtl/range_median_slew_filter_top.sv
// Sequence: a normal item is accepted in ST_IDLE; the rank unit then visits window slots
//   from slot 0 until it finds the median (ST_RANK); ST_DIFF and ST_SLEW follow, and
//   ST_HOLD loads the result into the output register once it is free. An alarm item goes
//   from ST_IDLE straight to ST_HOLD. A new item is accepted only in ST_IDLE, after the last
//   has been loaded; the rank unit visits one candidate slot per cycle in ST_RANK.
// Reset (synchronous, active high): window cleared to zero, write slot 0, last output 100,
//   registers to 400 / 20 / 50, output register empty.
module range_median_slew_filter_top (
  input  logic                                clk,
  input  logic                                rst,
  rmsf_in_if.sink                             sample,
  rmsf_out_if.source                          result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rmsf_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [rmsf_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rmsf_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  rmsf_pkg::cfg_t   cfg;
  rmsf_pkg::state_t state;
  rmsf_pkg::state_t state_next;
  rmsf_pkg::rank_t  rank;

  // Circular window and its write slot.
  rmsf_pkg::win_t                     win;
  logic [rmsf_pkg::WIN_IDX_W-1:0]     wpos;
  logic [rmsf_pkg::WIN_IDX_W-1:0]     cand;

  logic [rmsf_pkg::DATA_W-1:0]        last_out;
  logic [rmsf_pkg::DATA_W-1:0]        med;
  logic [rmsf_pkg::DATA_W-1:0]        diff;
  logic                               up;
  logic [rmsf_pkg::DATA_W-1:0]        res;

  // Output register: holds a finished result until the sink takes it.
  logic                               out_valid;
  logic [rmsf_pkg::DATA_W-1:0]        out_data;

  logic                               accept;
  logic                               over_range;
  logic                               alarm;
  logic [rmsf_pkg::DATA_W-1:0]        reading;
  logic                               is_med;
  logic                               out_free;
  logic                               load_out;
  logic [rmsf_pkg::DATA_W:0]          up_sum;
  logic [rmsf_pkg::DATA_W-1:0]        slew_val;

  rmsf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Shared rank unit: one candidate slot per cycle against the whole window.
  rmsf_rank u_rank (
    .win  (win),
    .cand (win[cand]),
    .rank (rank)
  );

  assign is_med = (rank.lt_cnt <= rmsf_pkg::CNT_W'(rmsf_pkg::MED_RANK)) &&
                  (rank.le_cnt >  rmsf_pkg::CNT_W'(rmsf_pkg::MED_RANK));

  assign accept     = sample.valid && sample.ready;
  assign over_range = sample.raw_distance > cfg.valid_limit;
  assign alarm      = over_range && (last_out < cfg.near_limit);
  assign reading    = over_range ? cfg.valid_limit : sample.raw_distance;

  assign out_free = !out_valid || result.ready;

  // Slew by a fixed step toward the median, saturating at both bounds.
  assign up_sum = {1'b0, last_out} + {1'b0, rmsf_pkg::SLEW_STEP};
  always_comb begin
    if (up) begin
      slew_val = up_sum[rmsf_pkg::DATA_W] ? {rmsf_pkg::DATA_W{1'b1}}
                                          : up_sum[rmsf_pkg::DATA_W-1:0];
    end else begin
      slew_val = (last_out < rmsf_pkg::SLEW_STEP) ? '0 : last_out - rmsf_pkg::SLEW_STEP;
    end
  end

  // Sequencer: next state and handshake outputs.
  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    load_out     = 1'b0;
    case (state)
      rmsf_pkg::ST_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) begin
          state_next = alarm ? rmsf_pkg::ST_HOLD : rmsf_pkg::ST_RANK;
        end
      end
      rmsf_pkg::ST_RANK: begin
        if (is_med) begin
          state_next = rmsf_pkg::ST_DIFF;
        end
      end
      rmsf_pkg::ST_DIFF: begin
        state_next = rmsf_pkg::ST_SLEW;
      end
      rmsf_pkg::ST_SLEW: begin
        state_next = rmsf_pkg::ST_HOLD;
      end
      rmsf_pkg::ST_HOLD: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = rmsf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rmsf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmsf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window, slot pointer and last output.
  always_ff @(posedge clk) begin
    if (rst) begin
      win      <= '0;
      wpos     <= '0;
      last_out <= rmsf_pkg::LAST_RESET;
    end else begin
      if (accept && !alarm) begin
        win[wpos] <= reading;
        if (wpos == rmsf_pkg::WIN_IDX_W'(rmsf_pkg::WINDOW_SIZE - 1)) begin
          wpos <= '0;
        end else begin
          wpos <= wpos + rmsf_pkg::WIN_IDX_W'(1);
        end
      end
      if (state == rmsf_pkg::ST_SLEW) begin
        last_out <= (diff > cfg.jump_limit) ? slew_val : med;
      end
    end
  end

  // Working registers of the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cand <= '0;
    end else begin
      case (state)
        rmsf_pkg::ST_IDLE: begin
          cand <= '0;
        end
        rmsf_pkg::ST_RANK: begin
          if (!is_med) begin
            cand <= cand + rmsf_pkg::WIN_IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rmsf_pkg::ST_IDLE: begin
        // An alarm item bypasses the window: its result is registered here on accept.
        if (accept) begin
          res <= rmsf_pkg::ALARM_VALUE;
        end
      end
      rmsf_pkg::ST_RANK: begin
        if (is_med) begin
          med <= win[cand];
        end
      end
      rmsf_pkg::ST_DIFF: begin
        up   <= med > last_out;
        diff <= (med > last_out) ? med - last_out : last_out - med;
      end
      rmsf_pkg::ST_SLEW: begin
        res <= (diff > cfg.jump_limit) ? slew_val : med;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= res;
    end
  end

  assign result.valid             = out_valid;
  assign result.filtered_distance = out_data;

endmodule

>>> hw/rtl/rmsf_cfg.sv
module rmsf_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rmsf_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [rmsf_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rmsf_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output rmsf_pkg::cfg_t                      cfg
);

  rmsf_pkg::cfg_reg_t reg_sel;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_sel = rmsf_pkg::cfg_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.valid_limit <= rmsf_pkg::MAX_VALID_RESET;
      cfg.near_limit  <= rmsf_pkg::NEAR_ZONE_RESET;
      cfg.jump_limit  <= rmsf_pkg::MAX_JUMP_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        rmsf_pkg::REG_MAX_VALID: begin
          cfg.valid_limit <= pwdata[rmsf_pkg::DATA_W-1:0];
        end
        rmsf_pkg::REG_NEAR_ZONE: begin
          cfg.near_limit <= pwdata[rmsf_pkg::DATA_W-1:0];
        end
        rmsf_pkg::REG_MAX_JUMP: begin
          cfg.jump_limit <= pwdata[rmsf_pkg::DATA_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rmsf_pkg::REG_MAX_VALID: begin
        prdata = {{(rmsf_pkg::APB_DATA_W-rmsf_pkg::DATA_W){1'b0}}, cfg.valid_limit};
      end
      rmsf_pkg::REG_NEAR_ZONE: begin
        prdata = {{(rmsf_pkg::APB_DATA_W-rmsf_pkg::DATA_W){1'b0}}, cfg.near_limit};
      end
      rmsf_pkg::REG_MAX_JUMP: begin
        prdata = {{(rmsf_pkg::APB_DATA_W-rmsf_pkg::DATA_W){1'b0}}, cfg.jump_limit};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

endmodule

>>> hw/rtl/rmsf_rank.sv
module rmsf_rank (
  input  rmsf_pkg::win_t                 win,
  input  logic [rmsf_pkg::DATA_W-1:0]    cand,
  output rmsf_pkg::rank_t                rank
);

  // Count window entries below and not above the candidate.
  always_comb begin
    rank.lt_cnt = '0;
    rank.le_cnt = '0;
    for (int i = 0; i < rmsf_pkg::WINDOW_SIZE; i++) begin
      if (win[i] < cand) begin
        rank.lt_cnt = rank.lt_cnt + rmsf_pkg::CNT_W'(1);
      end
      if (win[i] <= cand) begin
        rank.le_cnt = rank.le_cnt + rmsf_pkg::CNT_W'(1);
      end
    end
  end

endmodule
